[hw/rtl/tcce_pkg.sv]
package tcce_pkg;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_NL    = 3'd1;
  localparam logic [2:0] CMD_BS    = 3'd2;
  localparam logic [2:0] CMD_CLR   = 3'd3;
  localparam logic [2:0] CMD_FG    = 3'd4;
  localparam logic [2:0] CMD_BG    = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  localparam logic [7:0] NL_CODE    = 8'h0A;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef logic [15:0] cell_t;

endpackage

[hw/rtl/text_console_cursor_engine_top.sv]
// Text console engine: keeps a COLUMNS x ROWS screen of 16-bit cells (attribute high byte,
// character low byte) in one single-port-write, registered-read memory, plus the cursor and
// the current attribute. Each item carries one command and gives exactly one result with the
// cursor and attribute after it. Put char and newline that do not scroll, backspace, set
// foreground and a read outside the screen go straight to the output register, so they run
// back to back. A read inside the screen passes through the memory's registered read and a
// read state. Commands that sweep walk the memory one cell per cycle and hold off new items
// until done: clear all and set background blank the whole screen, a scroll blanks rows 1 to
// ROWS-2 and puts the cursor at the start of row 1. After reset the block blanks the whole
// screen, with no result, before it takes its first item. A finished result sits in an
// output register; a new item is taken only in a cycle where that register is empty or its
// result is leaving, so a stalled result holds off the input.
module text_console_cursor_engine_top
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  cmd,
  input  logic [7:0]  ch,
  input  logic [3:0]  color,
  input  logic [10:0] cell_addr,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [6:0]  cursor_x,
  output logic [4:0]  cursor_y,
  output logic [10:0] cursor_pos,
  output logic [15:0] cell_data,
  output logic [7:0]  attribute
);

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int MEM_AW = $clog2(NCELLS);
  localparam int POS_W  = $clog2(NCELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]  NL_CLR_ROW = ROW_W'(ROWS - 2);
  localparam logic [POS_W-1:0]  COLS_POS   = POS_W'(COLUMNS);
  localparam logic [MEM_AW-1:0] MID_FIRST  = MEM_AW'(COLUMNS);
  localparam logic [MEM_AW-1:0] MID_LAST   = MEM_AW'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [MEM_AW-1:0] ALL_LAST   = MEM_AW'(NCELLS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;

  logic [1:0]        state;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [POS_W-1:0]  pos;
  logic [7:0]        attr;
  logic [MEM_AW-1:0] ptr;
  logic [MEM_AW-1:0] ptr_last;
  logic              sweep_emit;

  cell_t             mem [0:NCELLS-1];
  cell_t             rd_data;

  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [POS_W-1:0]  pos_next;
  logic [7:0]        attr_next;
  logic              cmd_we;
  logic [MEM_AW-1:0] cmd_wa;
  cell_t             cmd_wd;
  logic              do_sweep;
  logic [MEM_AW-1:0] sweep_first;
  logic [MEM_AW-1:0] sweep_last;
  logic              do_read;

  logic              accept;
  logic              sweep_end;
  logic              out_load;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  cell_t             mem_wd;
  cell_t             blank;

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign blank     = {attr, SPACE_CODE};
  assign sweep_end = (state == S_SWEEP) && (ptr == ptr_last);

  always_comb begin
    col_next    = col;
    row_next    = row;
    pos_next    = pos;
    attr_next   = attr;
    cmd_we      = 1'b0;
    cmd_wa      = MEM_AW'(pos);
    cmd_wd      = {attr, ch};
    do_sweep    = 1'b0;
    sweep_first = MID_FIRST;
    sweep_last  = MID_LAST;
    do_read     = 1'b0;
    case (cmd)
      CMD_PUT: begin
        if (ch == NL_CODE) begin
          if (row == LAST_ROW) begin
            do_sweep = 1'b1;
          end else begin
            col_next = '0;
            row_next = row + ROW_W'(1);
            pos_next = pos - POS_W'(col) + COLS_POS;
          end
        end else begin
          cmd_we = 1'b1;
          if (col == LAST_COL) begin
            if (row == LAST_ROW) begin
              do_sweep = 1'b1;
            end else begin
              col_next = '0;
              row_next = row + ROW_W'(1);
              pos_next = pos + POS_W'(1);
            end
          end else begin
            col_next = col + COL_W'(1);
            pos_next = pos + POS_W'(1);
          end
        end
      end
      CMD_NL: begin
        if (row >= NL_CLR_ROW) begin
          do_sweep = 1'b1;
        end else begin
          col_next = '0;
          row_next = row + ROW_W'(1);
          pos_next = pos - POS_W'(col) + COLS_POS;
        end
      end
      CMD_BS: begin
        if (!(col == '0 && row == '0)) begin
          pos_next = pos - POS_W'(1);
          cmd_we   = 1'b1;
          cmd_wa   = MEM_AW'(pos - POS_W'(1));
          cmd_wd   = blank;
          if (col != '0) begin
            col_next = col - COL_W'(1);
          end else begin
            col_next = LAST_COL;
            row_next = row - ROW_W'(1);
          end
        end
      end
      CMD_CLR: begin
        do_sweep    = 1'b1;
        sweep_first = '0;
        sweep_last  = ALL_LAST;
      end
      CMD_FG: begin
        attr_next = {attr[7:4], color};
      end
      CMD_BG: begin
        attr_next   = {color, attr[3:0]};
        do_sweep    = 1'b1;
        sweep_first = '0;
        sweep_last  = ALL_LAST;
      end
      CMD_READ: begin
        do_read = (32'(cell_addr) < 32'(NCELLS));
      end
      default: begin
      end
    endcase
    // a full clear homes the cursor, a scroll puts it at the start of row 1
    if (do_sweep) begin
      if (sweep_first == '0) begin
        col_next = '0;
        row_next = '0;
        pos_next = '0;
      end else begin
        col_next = '0;
        row_next = ROW_W'(1);
        pos_next = COLS_POS;
      end
    end
  end

  assign out_load = (state == S_READ) || (sweep_end && sweep_emit) ||
                    ((state == S_IDLE) && accept && !do_sweep && !do_read);

  assign mem_we = (state == S_SWEEP) || (accept && cmd_we);
  assign mem_wa = (state == S_SWEEP) ? ptr : cmd_wa;
  assign mem_wd = (state == S_SWEEP) ? blank : cmd_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept && do_read) begin
      rd_data <= mem[MEM_AW'(cell_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      ptr        <= '0;
      ptr_last   <= ALL_LAST;
      sweep_emit <= 1'b0;
      col        <= '0;
      row        <= '0;
      pos        <= '0;
      attr       <= RESET_ATTR;
      rsp_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            col  <= col_next;
            row  <= row_next;
            pos  <= pos_next;
            attr <= attr_next;
            if (do_sweep) begin
              state      <= S_SWEEP;
              ptr        <= sweep_first;
              ptr_last   <= sweep_last;
              sweep_emit <= 1'b1;
            end else if (do_read) begin
              state <= S_READ;
            end
          end
        end
        S_SWEEP: begin
          ptr <= ptr + MEM_AW'(1);
          if (sweep_end) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_IDLE) begin
        cursor_x   <= 7'(col_next);
        cursor_y   <= 5'(row_next);
        cursor_pos <= 11'(pos_next);
        attribute  <= attr_next;
        cell_data  <= '0;
      end else begin
        cursor_x   <= 7'(col);
        cursor_y   <= 5'(row);
        cursor_pos <= 11'(pos);
        attribute  <= attr;
        cell_data  <= (state == S_READ) ? rd_data : '0;
      end
    end
  end

endmodule
